>>> rtl/wdd_pkg.sv
// Shared constants and types for the waypoint delta decoder.
`timescale 1ns / 1ps
`default_nettype none

package wdd_pkg;

  // Block limits
  localparam int MAX_COORDS = 64;
  localparam int FLAG_BYTES = 16;
  localparam int FLAG_AW    = (FLAG_BYTES > 1) ? $clog2(FLAG_BYTES) : 1;

  // Decoder phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_X0   = 3'd2;
  localparam logic [2:0] PH_X1   = 3'd3;
  localparam logic [2:0] PH_Y0   = 3'd4;
  localparam logic [2:0] PH_Y1   = 3'd5;

  // Write port of the flag store
  typedef struct packed {
    logic               en;
    logic [FLAG_AW-1:0] addr;
    logic [7:0]         data;
  } wdd_wr_t;

  // One decoded waypoint
  typedef struct packed {
    logic        is_last;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } wdd_res_t;

endpackage

`default_nettype wire

>>> rtl/wdd_flag_ram.sv
// Flag header store: one write port, one registered read port with write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module wdd_flag_ram (
  input  wire                         clk,
  input  wdd_pkg::wdd_wr_t            wr,
  input  wire [wdd_pkg::FLAG_AW-1:0]  rd_addr,
  output logic [7:0]                  rd_data
);
  import wdd_pkg::*;

  logic [7:0] mem [FLAG_BYTES];
  logic [7:0] rd_data_r;

  // Write, and registered read; a same-cycle write to the read address wins
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/waypoint_delta_decoder_top.sv
// Top level of the waypoint delta decoder.
//
// Input channel (in_*): one raw byte of a waypoint block per word. in_tuser
// high marks the first byte of a block; coord_count is sampled with it.
// The block restarts on that word, the flag header follows and is kept in a
// small synchronous flag memory, then x/y fields of each vector follow.
// Output channel (out_*): one word per completed vector, x in the low half,
// y in the high half, out_tlast high on the final waypoint of the block.
// Throughput: one byte per cycle while in_tready is high. The flag byte
// for the current vector is fetched from the flag memory in the cycle
// before it is used, addressed from the next vector index, so the lookup
// adds no delay to the byte path. The byte that completes a vector has its
// result registered in the output register, or in the skid stage on a stall.
// Stall: results go to an output register backed by a one-word skid stage;
// in_tready drops only while both hold a word.
// Reset: rst_n low (synchronous) returns the decoder to idle and empties the
// output stages; bytes seen while idle without a block start are dropped.
`timescale 1ns / 1ps
`default_nettype none

module waypoint_delta_decoder_top (
  input  wire         clk,
  input  wire         rst_n,
  // input word
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] in_byte, [14:8] coord_count, [15] zero
  input  wire         in_tuser,   // block_start
  // result word
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [15:0] pos_x, [31:16] pos_y
  output logic        out_tlast   // is_last
);
  import wdd_pkg::*;

  // Decoder state
  logic [2:0]  phase_r, phase_nxt;
  logic [4:0]  hdr_left_r, hdr_left_nxt;
  logic [4:0]  hdr_pos_r, hdr_pos_nxt;
  logic [5:0]  vec_idx_r, vec_idx_nxt;
  logic [5:0]  vec_tot_r, vec_tot_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic [15:0] run_x_r, run_x_nxt;
  logic [15:0] run_y_r, run_y_nxt;

  // Output register and skid stage
  logic        out_vld_r, skid_vld_r;
  wdd_res_t    out_r, skid_r;

  logic        accept;
  logic [7:0]  in_byte;
  logic [6:0]  coord_count;
  logic        block_start;

  logic [6:0]  cnt_c;
  logic [7:0]  cnt_sum;
  logic [4:0]  start_hdr;
  logic [5:0]  start_vtot;

  logic [2:0]  ph_e;
  logic [4:0]  hl_e;
  logic [4:0]  hp_e;
  logic [5:0]  vi_e;
  logic [5:0]  vt_e;

  logic [5:0]  vm1;
  logic [3:0]  flag_byte;
  logic        flag_in_store;
  logic [7:0]  rd_data;
  logic        flag_x, flag_y;
  logic [5:0]  vm1_nxt;
  logic [3:0]  rd_byte;

  logic        produce;
  wdd_res_t    res;
  wdd_wr_t     wr;
  logic [4:0]  hl_dec;
  logic [6:0]  vi_inc7;
  logic [15:0] dx, dy;

  assign in_byte     = in_tdata[7:0];
  assign coord_count = in_tdata[14:8];
  assign block_start = in_tuser;
  assign in_tready   = !skid_vld_r;
  assign accept      = in_tvalid && in_tready;

  // Block start: clamp count, size the header and vector run
  assign cnt_c      = (coord_count > 7'(MAX_COORDS)) ? 7'(MAX_COORDS) : coord_count;
  assign cnt_sum    = {1'b0, cnt_c} + 8'd5;
  assign start_hdr  = cnt_sum[7:3] + {4'd0, cnt_c[0]};
  assign start_vtot = cnt_c[6:1];

  always_comb begin
    if (block_start) begin
      hl_e = start_hdr;
      hp_e = 5'd0;
      vi_e = 6'd0;
      vt_e = start_vtot;
      if (start_hdr != 5'd0) begin
        ph_e = PH_HDR;
      end else if (start_vtot != 6'd0) begin
        ph_e = PH_X0;
      end else begin
        ph_e = PH_IDLE;
      end
    end else begin
      hl_e = hdr_left_r;
      hp_e = hdr_pos_r;
      vi_e = vec_idx_r;
      vt_e = vec_tot_r;
      ph_e = phase_r;
    end
  end

  // Flag bits of the current vector from the prefetched flag byte
  assign vm1           = vec_idx_r - 6'd1;
  assign flag_byte     = vm1[5:2];
  assign flag_in_store = ({1'b0, flag_byte} < 5'(FLAG_BYTES));
  assign flag_x = (vi_e != 6'd0) && flag_in_store && rd_data[{vm1[1:0], 1'b0}];
  assign flag_y = (vi_e != 6'd0) && flag_in_store && rd_data[{vm1[1:0], 1'b1}];

  // Sign-extended deltas
  assign dx = {{8{in_byte[7]}}, in_byte};
  assign dy = {{8{in_byte[7]}}, in_byte};

  assign hl_dec  = hl_e - 5'd1;
  assign vi_inc7 = {1'b0, vi_e} + 7'd1;

  // Byte decode
  always_comb begin
    phase_nxt    = phase_r;
    hdr_left_nxt = hdr_left_r;
    hdr_pos_nxt  = hdr_pos_r;
    vec_idx_nxt  = vec_idx_r;
    vec_tot_nxt  = vec_tot_r;
    low_hold_nxt = low_hold_r;
    run_x_nxt    = run_x_r;
    run_y_nxt    = run_y_r;
    produce      = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = hp_e[FLAG_AW-1:0];
    wr.data      = in_byte;
    res.pos_x    = run_x_r;
    res.pos_y    = run_y_r;
    res.is_last  = 1'b0;
    if (accept) begin
      phase_nxt    = ph_e;
      hdr_left_nxt = hl_e;
      hdr_pos_nxt  = hp_e;
      vec_idx_nxt  = vi_e;
      vec_tot_nxt  = vt_e;
      case (ph_e)
        PH_HDR: begin
          wr.en        = (hp_e < 5'(FLAG_BYTES));
          hdr_pos_nxt  = hp_e + 5'd1;
          hdr_left_nxt = hl_dec;
          if (hl_dec == 5'd0) begin
            phase_nxt = (vt_e != 6'd0) ? PH_X0 : PH_IDLE;
          end
        end
        PH_X0: begin
          if (flag_x) begin
            run_x_nxt = run_x_r + dx;
            phase_nxt = PH_Y0;
          end else begin
            low_hold_nxt = in_byte;
            phase_nxt    = PH_X1;
          end
        end
        PH_X1: begin
          run_x_nxt = {in_byte, low_hold_r};
          phase_nxt = PH_Y0;
        end
        PH_Y0: begin
          if (flag_y) begin
            run_y_nxt = run_y_r + dy;
            produce   = 1'b1;
          end else begin
            low_hold_nxt = in_byte;
            phase_nxt    = PH_Y1;
          end
        end
        PH_Y1: begin
          run_y_nxt = {in_byte, low_hold_r};
          produce   = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
      // Vector complete
      if (produce) begin
        res.pos_x   = run_x_nxt;
        res.pos_y   = run_y_nxt;
        res.is_last = (vi_inc7 >= {1'b0, vt_e});
        vec_idx_nxt = vi_inc7[5:0];
        phase_nxt   = (vi_inc7[5:0] >= vt_e) ? PH_IDLE : PH_X0;
      end
    end
  end

  // Prefetch the flag byte the next vector will use
  assign vm1_nxt = vec_idx_nxt - 6'd1;
  assign rd_byte = vm1_nxt[5:2];

  wdd_flag_ram u_flag_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_byte[FLAG_AW-1:0]),
    .rd_data (rd_data)
  );

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hdr_left_r <= 5'd0;
      hdr_pos_r  <= 5'd0;
      vec_idx_r  <= 6'd0;
      vec_tot_r  <= 6'd0;
      low_hold_r <= 8'd0;
      run_x_r    <= 16'd0;
      run_y_r    <= 16'd0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_left_r <= hdr_left_nxt;
      hdr_pos_r  <= hdr_pos_nxt;
      vec_idx_r  <= vec_idx_nxt;
      vec_tot_r  <= vec_tot_nxt;
      low_hold_r <= low_hold_nxt;
      run_x_r    <= run_x_nxt;
      run_y_r    <= run_y_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= produce;
      end
    end else if (produce) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      out_r <= skid_vld_r ? skid_r : res;
    end
    if (produce) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.pos_y, out_r.pos_x};
  assign out_tlast  = out_r.is_last;

endmodule

`default_nettype wire

>>> rtl/wdd_checker.sv
// Port-level checks for the waypoint delta decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wdd_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        in_tuser,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tlast
);

  // Reset empties the output stages
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word present right after reset");

  // Input back-pressure only while a result is pending
  a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // A block's first byte never completes a vector
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser && !out_tvalid) |=> !out_tvalid)
    else $error("result produced by a block start byte");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result word changed");

endmodule

bind waypoint_delta_decoder_top wdd_checker u_wdd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
